// ----- src/cbf_pkg.sv -----
// Package with shared types and datapath command codes for the Bezier flattener.
`timescale 1ns / 1ps
package cbf_pkg;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   run_last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TOL,
    OP_POP,
    OP_MID,
    OP_LEN0,
    OP_LEN1,
    OP_DOT0,
    OP_DOT1,
    OP_TINIT,
    OP_DIV,
    OP_EX,
    OP_EY,
    OP_SQX,
    OP_SQY,
    OP_DECIDE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic split;
    logic stack_empty;
  } dp_status_t;

  localparam logic [15:0] TOL_RESET = 16'd115;
  localparam int          DIV_STEPS = 16;

endpackage

// ----- src/cbf_ctrl.sv -----
// Sequencer that steps the datapath through pop, test, divide when needed and, for leaf pieces, emit.
`timescale 1ns / 1ps
module cbf_ctrl
  import cbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TOL    = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_MID    = 4'd3;
  localparam logic [3:0] S_LEN0   = 4'd4;
  localparam logic [3:0] S_LEN1   = 4'd5;
  localparam logic [3:0] S_DOT0   = 4'd6;
  localparam logic [3:0] S_DOT1   = 4'd7;
  localparam logic [3:0] S_TINIT  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_EX     = 4'd10;
  localparam logic [3:0] S_EY     = 4'd11;
  localparam logic [3:0] S_SQX    = 4'd12;
  localparam logic [3:0] S_SQY    = 4'd13;
  localparam logic [3:0] S_DECIDE = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  localparam int CW = $clog2(DIV_STEPS);

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_TOL;
        end
      end
      S_TOL: begin
        cmd_o.op = OP_TOL;
        state_d  = S_POP;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_MID;
      end
      S_MID: begin
        cmd_o.op = OP_MID;
        state_d  = S_LEN0;
      end
      S_LEN0: begin
        cmd_o.op = OP_LEN0;
        state_d  = S_LEN1;
      end
      S_LEN1: begin
        cmd_o.op = OP_LEN1;
        state_d  = S_DOT0;
      end
      S_DOT0: begin
        cmd_o.op = OP_DOT0;
        state_d  = S_DOT1;
      end
      S_DOT1: begin
        cmd_o.op = OP_DOT1;
        state_d  = S_TINIT;
      end
      S_TINIT: begin
        cmd_o.op = OP_TINIT;
        cnt_d    = '0;
        state_d  = status_i.need_div ? S_DIV : S_EX;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          state_d = S_EX;
        end
      end
      S_EX: begin
        cmd_o.op = OP_EX;
        state_d  = S_EY;
      end
      S_EY: begin
        cmd_o.op = OP_EY;
        state_d  = S_SQX;
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        state_d  = status_i.split ? S_POP : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          state_d = status_i.stack_empty ? S_IDLE : S_POP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- src/cbf_datapath.sv -----
// Piece stack, de Casteljau halving, shared multiplier and projection divider.
`timescale 1ns / 1ps
module cbf_datapath
  import cbf_pkg::*;
#(
  parameter int MAX_DEPTH = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  in_item_t    in_item_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CAP = MAX_DEPTH + 1;
  localparam int TW  = $clog2(CAP + 1);
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int LW  = $clog2(MAX_DEPTH + 1);

  logic [15:0]   tol_q;
  logic [31:0]   tol2_q;
  logic [TW-1:0] top_q;

  coord_t        sx_q [CAP][4];
  coord_t        sy_q [CAP][4];
  logic [LW-1:0] sl_q [CAP];

  coord_t        wx_q [4];
  coord_t        wy_q [4];
  logic [LW-1:0] wl_q;

  coord_t x01_q, x012_q, xm_q, x123_q, x23_q;
  coord_t y01_q, y012_q, ym_q, y123_q, y23_q;

  logic        [50:0] len_q;
  logic signed [51:0] dot_q;
  logic        [51:0] rem_q;
  logic        [16:0] t_q;
  logic signed [26:0] ex_q, ey_q;
  logic        [54:0] dist_q;
  out_item_t          out_q;

  function automatic coord_t halve(coord_t a, coord_t b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    return s[24:1];
  endfunction

  coord_t x01, x12, x23, x012, x123, xm;
  coord_t y01, y12, y23, y012, y123, ym;

  always_comb begin
    x01  = halve(wx_q[0], wx_q[1]);
    x12  = halve(wx_q[1], wx_q[2]);
    x23  = halve(wx_q[2], wx_q[3]);
    x012 = halve(x01, x12);
    x123 = halve(x12, x23);
    xm   = halve(x012, x123);
    y01  = halve(wy_q[0], wy_q[1]);
    y12  = halve(wy_q[1], wy_q[2]);
    y23  = halve(wy_q[2], wy_q[3]);
    y012 = halve(y01, y12);
    y123 = halve(y12, y23);
    ym   = halve(y012, y123);
  end

  logic signed [26:0] qx, qy, dx, dy;
  assign qx = 27'(wx_q[3]) - 27'(wx_q[0]);
  assign qy = 27'(wy_q[3]) - 27'(wy_q[0]);
  assign dx = 27'(xm_q) - 27'(wx_q[0]);
  assign dy = 27'(ym_q) - 27'(wy_q[0]);

  logic signed [26:0] mul_a, mul_b;
  logic signed [53:0] prod, prod_sh;
  logic signed [26:0] tq;

  assign tq = $signed({10'd0, t_q});

  always_comb begin
    mul_a = qx;
    mul_b = qx;
    case (cmd_i.op)
      OP_TOL: begin
        mul_a = $signed({11'd0, tol_q});
        mul_b = $signed({11'd0, tol_q});
      end
      OP_LEN1: begin
        mul_a = qy;
        mul_b = qy;
      end
      OP_DOT0: mul_b = dx;
      OP_DOT1: begin
        mul_a = qy;
        mul_b = dy;
      end
      OP_EX: mul_b = tq;
      OP_EY: begin
        mul_a = qy;
        mul_b = tq;
      end
      OP_SQX: begin
        mul_a = ex_q;
        mul_b = ex_q;
      end
      OP_SQY: begin
        mul_a = ey_q;
        mul_b = ey_q;
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> 16;

  logic        trivial_t, full_t;
  logic [51:0] rem_sh;
  logic        rem_ge;
  logic [TW:0] top_plus2;
  logic        split;

  assign trivial_t = (len_q == '0) || (dot_q <= 0);
  assign full_t    = $unsigned(dot_q) >= {1'b0, len_q};
  assign rem_sh    = {rem_q[50:0], 1'b0};
  assign rem_ge    = rem_sh >= {1'b0, len_q};
  assign top_plus2 = (TW + 1)'(top_q) + (TW + 1)'(2);
  assign split     = (wl_q < LW'(MAX_DEPTH)) && (top_plus2 <= (TW + 1)'(CAP)) &&
                     (dist_q > {23'd0, tol2_q});

  assign status_o.need_div    = !trivial_t && !full_t;
  assign status_o.split       = split;
  assign status_o.stack_empty = (top_q == '0);
  assign out_item_o           = out_q;

  logic [IW-1:0] top_idx, pop_idx, nxt_idx;
  assign top_idx = top_q[IW-1:0];
  assign pop_idx = IW'(top_q - 1'b1);
  assign nxt_idx = IW'(top_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      top_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      case (cmd_i.op)
        OP_LOAD:  top_q <= TW'(1);
        OP_POP:   top_q <= top_q - 1'b1;
        OP_DECIDE: begin
          if (split) begin
            top_q <= top_plus2[TW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sx_q[0][0] <= in_item_i.start_x;
        sx_q[0][1] <= in_item_i.ctrl1_x;
        sx_q[0][2] <= in_item_i.ctrl2_x;
        sx_q[0][3] <= in_item_i.end_x;
        sy_q[0][0] <= in_item_i.start_y;
        sy_q[0][1] <= in_item_i.ctrl1_y;
        sy_q[0][2] <= in_item_i.ctrl2_y;
        sy_q[0][3] <= in_item_i.end_y;
        sl_q[0]    <= '0;
      end
      OP_TOL: tol2_q <= prod[31:0];
      OP_POP: begin
        wx_q <= sx_q[pop_idx];
        wy_q <= sy_q[pop_idx];
        wl_q <= sl_q[pop_idx];
      end
      OP_MID: begin
        x01_q <= x01;  x012_q <= x012;  xm_q <= xm;  x123_q <= x123;  x23_q <= x23;
        y01_q <= y01;  y012_q <= y012;  ym_q <= ym;  y123_q <= y123;  y23_q <= y23;
      end
      OP_LEN0: len_q <= prod[50:0];
      OP_LEN1: len_q <= len_q + prod[50:0];
      OP_DOT0: dot_q <= prod[51:0];
      OP_DOT1: dot_q <= dot_q + prod[51:0];
      OP_TINIT: begin
        rem_q <= $unsigned(dot_q);
        if (trivial_t) begin
          t_q <= '0;
        end else if (full_t) begin
          t_q <= 17'h10000;
        end else begin
          t_q <= '0;
        end
      end
      OP_DIV: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, len_q} : rem_sh;
        t_q   <= {t_q[15:0], rem_ge};
      end
      OP_EX: ex_q <= 27'(wx_q[0]) + prod_sh[26:0] - 27'(xm_q);
      OP_EY: ey_q <= 27'(wy_q[0]) + prod_sh[26:0] - 27'(ym_q);
      OP_SQX: dist_q <= {1'b0, prod};
      OP_SQY: dist_q <= dist_q + {1'b0, prod};
      OP_DECIDE: begin
        if (split) begin
          sx_q[top_idx] <= '{xm_q, x123_q, x23_q, wx_q[3]};
          sy_q[top_idx] <= '{ym_q, y123_q, y23_q, wy_q[3]};
          sl_q[top_idx] <= wl_q + 1'b1;
          sx_q[nxt_idx] <= '{wx_q[0], x01_q, x012_q, xm_q};
          sy_q[nxt_idx] <= '{wy_q[0], y01_q, y012_q, ym_q};
          sl_q[nxt_idx] <= wl_q + 1'b1;
        end else begin
          out_q.vertex_x <= wx_q[3];
          out_q.vertex_y <= wy_q[3];
          out_q.run_last <= (top_q == '0);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(CAP))
    else $error("piece stack overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_POP |-> top_q != '0)
    else $error("pop from empty stack");
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DECIDE && split) |=> top_q <= TW'(CAP) && top_q >= TW'(2))
    else $error("split left stack inconsistent");
`endif

endmodule

// ----- src/cubic_bezier_flattener_core.sv -----
// Top level of the adaptive cubic Bezier flattener.
// Each tested piece steps through the test states, plus the projection divider when needed.
// Per segment: load and tolerance setup, then up to 127 pieces; each leaf holds in emit until out_ready_i.
// One segment at a time: in_ready_o is high only while no segment is in flight.
// The shared 27x27 multiplier and the one-bit-per-cycle divider serialize these steps.
// rst_ni clears the controller and stack count and sets tolerance to 115.
`timescale 1ns / 1ps
module cubic_bezier_flattener_core
  import cbf_pkg::*;
#(
  parameter int MAX_DEPTH = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbf_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
